[rtl/rmst_pkg.sv]
// shared types and constants for the range-minimum segment tree
// no dependencies; imported by rmst_ram users and range_minimum_segment_tree
`default_nettype none

package rmst_pkg;

  // leaf count and its power-of-two padding
  localparam int unsigned LEAVES   = 1024;
  localparam int unsigned PADDED   = 1024;
  localparam int unsigned LEAF_W   = 10;
  localparam int unsigned RANGE_W  = 11;
  localparam int unsigned NODE_AW  = 11;
  localparam int unsigned NODE_DEPTH = 2 * PADDED;
  localparam int unsigned IDX_W    = NODE_AW + 1;
  localparam int unsigned KEY_W    = 32;

  localparam logic [KEY_W-1:0] KEY_MAX   = '1;
  localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

  localparam logic [RANGE_W-1:0] PAD_RANGE = RANGE_W'(PADDED);
  localparam logic [IDX_W-1:0]   PAD_IDX   = IDX_W'(PADDED);
  localparam logic [IDX_W-1:0]   LEAF_LIM  = IDX_W'(LEAVES);
  localparam logic [NODE_AW-1:0] PAD_NODE  = NODE_AW'(PADDED);
  localparam logic [NODE_AW-1:0] ROOT_NODE = NODE_AW'(1);

  typedef enum logic {
    REQ_UPDATE = 1'b0,
    REQ_QUERY  = 1'b1
  } req_e;

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_UPD_LEAF = 6'b000100,
    ST_UPD_UP   = 6'b001000,
    ST_QRY_STEP = 6'b010000,
    ST_QRY_OUT  = 6'b100000
  } state_e;

  typedef logic [KEY_W-1:0] key_t;

  function automatic key_t key_min(input key_t a, input key_t b);
    key_min = (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

[rtl/rmst_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module rmst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/range_minimum_segment_tree.sv]
// range-minimum segment tree: update and half-open range-minimum query over one node ram
// depends on rmst_pkg and rmst_ram
// update: leaf write, then one ancestor a cycle up 10 levels to the root
// query: an empty range goes straight to the result; otherwise the bounds climb the tree,
//   with at most one node read a cycle through the single ram read port
// reset: a clearing pass writes every node to the largest value, with busy_o high
// results cannot be stalled; result_valid_o is high for one cycle per query item
`default_nettype none

module range_minimum_segment_tree (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          req_type_i,
  input  wire logic [rmst_pkg::LEAF_W-1:0]   leaf_index_i,
  input  wire logic signed [31:0]            new_value_i,
  input  wire logic [rmst_pkg::RANGE_W-1:0]  range_start_i,
  input  wire logic [rmst_pkg::RANGE_W-1:0]  range_end_i,
  output logic signed [31:0]                 range_min_o,
  output logic                               result_valid_o
);
  import rmst_pkg::*;

  state_e             state_q, state_d;
  logic [NODE_AW-1:0] clr_q, clr_d;
  logic [NODE_AW-1:0] node_q, node_d;
  key_t               cur_q, cur_d;
  logic [IDX_W-1:0]   l_q, l_d, r_q, r_d;
  key_t               best_q, best_d;
  logic               pend_q, pend_d;
  logic signed [31:0] range_min_q, range_min_d;
  logic               res_vld_q, res_vld_d;

  logic               mem_we;
  logic [NODE_AW-1:0] mem_waddr, mem_raddr;
  key_t               mem_wdata, mem_rdata;

  logic               accept;
  logic [RANGE_W-1:0] a_clamp, b_clamp;
  key_t               best_upd, up_min;
  logic [NODE_AW-1:0] parent;

  rmst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (NODE_DEPTH)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign accept  = start_i && !busy_o;
  assign a_clamp = (range_start_i > PAD_RANGE) ? PAD_RANGE : range_start_i;
  assign b_clamp = (range_end_i > PAD_RANGE) ? PAD_RANGE : range_end_i;
  // fold in the node read issued last cycle
  assign best_upd = pend_q ? key_min(best_q, mem_rdata) : best_q;
  assign up_min   = key_min(cur_q, mem_rdata);
  assign parent   = node_q >> 1;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    cur_d       = cur_q;
    l_d         = l_q;
    r_d         = r_q;
    best_d      = best_q;
    pend_d      = 1'b0;
    range_min_d = range_min_q;
    res_vld_d   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = node_q;
    mem_wdata   = cur_q;
    mem_raddr   = node_q ^ NODE_AW'(1);

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = KEY_MAX;
        clr_d     = clr_q + NODE_AW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_UPDATE) begin
            node_d = PAD_NODE + NODE_AW'(leaf_index_i);
            cur_d  = key_t'(new_value_i) ^ SIGN_FLIP;
            if (IDX_W'(leaf_index_i) < LEAF_LIM) begin
              state_d = ST_UPD_LEAF;
            end
          end else begin
            l_d    = IDX_W'(a_clamp) + PAD_IDX;
            r_d    = IDX_W'(b_clamp) + PAD_IDX;
            best_d = KEY_MAX;
            // empty range goes straight to the result
            state_d = (a_clamp >= b_clamp) ? ST_QRY_OUT : ST_QRY_STEP;
          end
        end
      end
      ST_UPD_LEAF: begin
        // write the leaf and fetch its sibling
        mem_we  = 1'b1;
        state_d = ST_UPD_UP;
      end
      ST_UPD_UP: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_min;
        mem_raddr = parent ^ NODE_AW'(1);
        cur_d     = up_min;
        node_d    = parent;
        if (parent == ROOT_NODE) begin
          state_d = ST_IDLE;
        end
      end
      ST_QRY_STEP: begin
        best_d    = best_upd;
        mem_raddr = l_q[NODE_AW-1:0];
        if (l_q >= r_q) begin
          state_d = ST_QRY_OUT;
        end else if (l_q[0]) begin
          pend_d = 1'b1;
          l_d    = l_q + IDX_W'(1);
        end else if (r_q[0]) begin
          mem_raddr = r_q[NODE_AW-1:0] - NODE_AW'(1);
          pend_d    = 1'b1;
          r_d       = r_q - IDX_W'(1);
        end else begin
          l_d = l_q >> 1;
          r_d = r_q >> 1;
        end
      end
      ST_QRY_OUT: begin
        range_min_d = signed'(best_upd ^ SIGN_FLIP);
        res_vld_d   = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      pend_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pend_q    <= pend_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q      <= node_d;
    cur_q       <= cur_d;
    l_q         <= l_d;
    r_q         <= r_d;
    best_q      <= best_d;
    range_min_q <= range_min_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign range_min_o    = range_min_q;
  assign result_valid_o = res_vld_q;

  a_result_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_QRY_OUT))
    else $error("result strobe without a finished query");

  a_out_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_QRY_OUT |=> result_valid_o)
    else $error("finished query gave no result");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && (state_q == ST_UPD_UP || state_q == ST_UPD_LEAF) |-> mem_waddr != mem_raddr)
    else $error("ancestor write collides with sibling read");

  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_QRY_STEP && $past(state_q == ST_QRY_STEP) |-> l_q <= r_q)
    else $error("query bounds crossed");

  a_pend_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == ST_QRY_STEP || state_q == ST_QRY_OUT)
    else $error("read pending outside a query");

endmodule

`default_nettype wire

[tb/range_minimum_segment_tree_tb.sv]
// testbench for range_minimum_segment_tree: leaf updates and half-open range-minimum queries
// checked against a leaf-array predictor in a small scoreboard class
// depends on rmst_pkg and the block's rtl only
`timescale 1ns / 100ps

module range_minimum_segment_tree_tb;
  import rmst_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 7;
  // clearing pass plus ~1800 items and long sender gaps, many times over
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 48;
  localparam int REPORT_MAX   = 10;

  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  class min_tree_scoreboard;
    logic signed [31:0] leaf_values [PADDED];
    logic signed [31:0] expected_mins [$];
    int unsigned mismatches;
    int unsigned updates;
    int unsigned queries;
    int unsigned checked;

    function new();
      foreach (leaf_values[i]) leaf_values[i] = INT_MAX;
      mismatches = 0;
      updates = 0;
      queries = 0;
      checked = 0;
    endfunction

    // both bounds clamped to the padded leaf count, empty range gives the largest value
    function logic signed [31:0] range_minimum(logic [RANGE_W-1:0] a, logic [RANGE_W-1:0] b);
      int unsigned lo;
      int unsigned hi;
      logic signed [31:0] best;
      lo = (a > PADDED) ? PADDED : a;
      hi = (b > PADDED) ? PADDED : b;
      best = INT_MAX;
      for (int unsigned i = lo; i < hi; i++) begin
        if (leaf_values[i] < best) best = leaf_values[i];
      end
      return best;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("mismatch: %s", msg);
    endfunction

    function void note_item(req_e kind, logic [LEAF_W-1:0] leaf, logic signed [31:0] value,
                            logic [RANGE_W-1:0] a, logic [RANGE_W-1:0] b);
      if (kind == REQ_UPDATE) begin
        updates++;
        if (leaf < LEAVES) leaf_values[leaf] = value;
      end else begin
        queries++;
        expected_mins.push_back(range_minimum(a, b));
      end
    endfunction

    function void check_result(logic signed [31:0] actual);
      logic signed [31:0] want;
      if (expected_mins.size() == 0) begin
        flag($sformatf("result %0d with no query outstanding", actual));
      end else begin
        want = expected_mins.pop_front();
        checked++;
        if (actual !== want)
          flag($sformatf("range_min expected %0d (%h) got %0d (%h)", want, want, actual, actual));
      end
    endfunction

    function void close_out();
      if (expected_mins.size() != 0)
        flag($sformatf("%0d query results never arrived", expected_mins.size()));
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic                      req_type_i;
  logic [LEAF_W-1:0]         leaf_index_i;
  logic signed [31:0]        new_value_i;
  logic [RANGE_W-1:0]        range_start_i;
  logic [RANGE_W-1:0]        range_end_i;
  logic signed [31:0]        range_min_o;
  logic                      result_valid_o;

  min_tree_scoreboard board;
  int unsigned items_accepted;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned window_base;

  range_minimum_segment_tree DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .leaf_index_i   (leaf_index_i),
    .new_value_i    (new_value_i),
    .range_start_i  (range_start_i),
    .range_end_i    (range_end_i),
    .range_min_o    (range_min_o),
    .result_valid_o (result_valid_o)
  );

  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items accepted", cycle_count, items_accepted);
      $display("status: fail");
      $finish;
    end
  end

  // results are checked before the item of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) board.check_result(range_min_o);
      if (start_i && !busy_o) begin
        board.note_item(req_e'(req_type_i), leaf_index_i, new_value_i, range_start_i,
                        range_end_i);
        items_accepted++;
      end
    end
  end

  task automatic send_item(req_e kind, int unsigned leaf, logic signed [31:0] value,
                           int unsigned a, int unsigned b);
    int unsigned seen;
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i       = 1'b0;
      req_type_i    = 1'($urandom_range(1));
      leaf_index_i  = LEAF_W'($urandom);
      new_value_i   = $urandom;
      range_start_i = RANGE_W'($urandom);
      range_end_i   = RANGE_W'($urandom);
      @(negedge clk_i);
    end
    start_i       = 1'b1;
    req_type_i    = kind;
    leaf_index_i  = LEAF_W'(leaf);
    new_value_i   = value;
    range_start_i = RANGE_W'(a);
    range_end_i   = RANGE_W'(b);
    seen = items_accepted;
    do @(negedge clk_i); while (items_accepted == seen);
  endtask

  task automatic settle();
    start_i = 1'b0;
    while (board.expected_mins.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return $signed($urandom_range(16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(int unsigned count);
    int unsigned a;
    int unsigned b;
    int unsigned leaf;
    repeat (count) begin
      // a moving window keeps updates and short queries on the same leaves
      if ($urandom_range(31) == 0) window_base = $urandom_range(LEAVES - 32);
      if ($urandom_range(1)) begin
        case ($urandom_range(9))
          0: begin
            a = $urandom_range(PADDED);
            b = a;
          end
          1: begin
            a = $urandom_range(PADDED, 1);
            b = $urandom_range(a - 1);
          end
          2: begin
            a = $urandom_range(2047);
            b = $urandom_range(2047, PADDED + 1);
          end
          3, 4: begin
            a = window_base + $urandom_range(31);
            b = a + $urandom_range(16, 1);
          end
          5: begin
            a = 0;
            b = PADDED;
          end
          default: begin
            a = $urandom_range(PADDED);
            b = $urandom_range(PADDED, a);
          end
        endcase
        send_item(REQ_QUERY, $urandom, $urandom, a, b);
      end else begin
        leaf = $urandom_range(1) ? window_base + $urandom_range(31) : $urandom_range(LEAVES - 1);
        send_item(REQ_UPDATE, leaf, pick_value(), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    board           = new();
    items_accepted  = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    window_base     = 0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    req_type_i      = REQ_UPDATE;
    leaf_index_i    = '0;
    new_value_i     = '0;
    range_start_i   = '0;
    range_end_i     = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // untouched tree, empty and reversed ranges
    send_item(REQ_QUERY, 0, 0, 0, PADDED);
    send_item(REQ_QUERY, 0, 0, 5, 5);
    send_item(REQ_QUERY, 0, 0, 9, 3);
    // extreme values at the end leaves and the middle
    send_item(REQ_UPDATE, 0, INT_MIN, 0, 0);
    send_item(REQ_UPDATE, LEAVES - 1, INT_MAX, 0, 0);
    send_item(REQ_UPDATE, 512, -1, 0, 0);
    send_item(REQ_UPDATE, 1, 0, 0, 0);
    send_item(REQ_QUERY, 0, 0, 0, 1);
    send_item(REQ_QUERY, 0, 0, 1, PADDED);
    send_item(REQ_QUERY, 0, 0, LEAVES - 1, PADDED);
    send_item(REQ_QUERY, 0, 0, 0, PADDED);
    send_item(REQ_QUERY, 0, 0, 512, 513);
    // bounds past the leaves are clamped
    send_item(REQ_QUERY, 0, 0, PADDED, 2047);
    send_item(REQ_QUERY, 0, 0, 500, 2047);
    send_item(REQ_QUERY, 0, 0, 2047, 0);
    send_item(REQ_UPDATE, 0, INT_MAX, 0, 0);
    send_item(REQ_QUERY, 0, 0, 0, PADDED);
    send_item(REQ_UPDATE, LEAVES - 1, INT_MIN, 0, 0);
    send_item(REQ_QUERY, 0, 0, LEAVES - 1, PADDED);
    send_item(REQ_QUERY, 0, 0, 511, LEAVES - 1);
    settle();

    sender_idle_pct = 0;
    random_items(600);
    settle();
    sender_idle_pct = 70;
    random_items(575);
    settle();
    sender_idle_pct = 28;
    random_items(575);
    settle();

    board.close_out();
    $display("ran %0d updates and %0d queries over idle rates of 0, 70 and 28 percent",
             board.updates, board.queries);
    $display("%0d query results checked, %0d mismatches", board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rmst_pkg.sv
rtl/rmst_ram.sv
rtl/range_minimum_segment_tree.sv
tb/range_minimum_segment_tree_tb.sv
